// ===== sv/wsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the work-stealing deque.
// ----------------------------------------------------------------------------
package wsd_pkg;

	localparam int DEPTH     = 256;
	localparam int TASK_BITS = 64;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int PTR_W     = IDX_W + 1;

	typedef logic [TASK_BITS-1:0] task_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [PTR_W-1:0]     ptr_t;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_STEAL = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_LOAD
	} state_t;

	typedef struct packed {
		logic exec;
		logic load;
	} wsd_cmd_t;

	typedef struct packed {
		logic out_stall;
	} wsd_sts_t;

endpackage

// ===== sv/wsd_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_req_if
// Request channel: one deque operation per request.
// ----------------------------------------------------------------------------
interface wsd_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [63:0] task_in;

	modport source (output valid, output operation, output task_in, input ready);
	modport sink   (input valid, input operation, input task_in, output ready);
endinterface

// ===== sv/wsd_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_rsp_if
// Response channel: status, task word and occupancy of one request.
// ----------------------------------------------------------------------------
interface wsd_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [63:0] task_out;
	logic [8:0]  occupancy;

	modport source (output valid, output status, output task_out, output occupancy,
		input ready);
	modport sink   (input valid, input status, input task_out, input occupancy,
		output ready);
endinterface

// ===== sv/wsd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_ctrl
// Controller: accepts a request, then loads its result into the output stage.
// ----------------------------------------------------------------------------
module wsd_ctrl import wsd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  wsd_sts_t sts,
	output wsd_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.exec  = req_valid;
				if (req_valid) begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.load = !sts.out_stall;
				if (!sts.out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== sv/wsd_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_dpath
// Datapath: task ring, top and bottom pointers, pending result and output stage.
// ----------------------------------------------------------------------------
module wsd_dpath import wsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  wsd_cmd_t   cmd,
	output wsd_sts_t   sts,
	input  logic [1:0] operation,
	input  task_t      task_in,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output logic [1:0] status,
	output task_t      task_out,
	output ptr_t       occupancy
);

	task_t   ring_mem [DEPTH];
	task_t   rd_q;
	ptr_t    top_q, bot_q;
	ptr_t    top_d, bot_d;
	ptr_t    occ_now, occ_next;
	logic    full, empty;
	logic    we, re;
	idx_t    ridx;
	status_t st_d;
	status_t res_status_q;
	ptr_t    res_occ_q;
	logic    res_take_q;
	status_t out_status_q;
	task_t   out_task_q;
	ptr_t    out_occ_q;
	logic    out_valid_q;

	assign occ_now = bot_q - top_q;
	assign full    = occ_now[PTR_W-1];
	assign empty   = (occ_now == '0);

	always_comb begin
		top_d = top_q;
		bot_d = bot_q;
		we    = 1'b0;
		re    = 1'b0;
		ridx  = top_q[IDX_W-1:0];
		st_d  = ST_OK;
		unique case (operation)
			OP_PUSH: begin
				if (full) begin
					st_d = ST_FULL;
				end else begin
					we    = cmd.exec;
					bot_d = bot_q + ptr_t'(1);
				end
			end
			OP_POP: begin
				if (empty) begin
					st_d = ST_EMPTY;
				end else begin
					re    = cmd.exec;
					bot_d = bot_q - ptr_t'(1);
					ridx  = bot_d[IDX_W-1:0];
				end
			end
			OP_STEAL: begin
				if (empty) begin
					st_d = ST_EMPTY;
				end else begin
					re    = cmd.exec;
					top_d = top_q + ptr_t'(1);
				end
			end
			default: st_d = ST_OK;
		endcase
	end

	assign occ_next = bot_d - top_d;

	always_ff @(posedge clk) begin
		if (we) begin
			ring_mem[bot_q[IDX_W-1:0]] <= task_in;
		end
		if (re) begin
			rd_q <= ring_mem[ridx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
			bot_q <= '0;
		end else if (cmd.exec) begin
			top_q <= top_d;
			bot_q <= bot_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_status_q <= st_d;
			res_occ_q    <= occ_next;
			res_take_q   <= re;
		end
		if (cmd.load) begin
			out_status_q <= res_status_q;
			out_task_q   <= res_take_q ? rd_q : '0;
			out_occ_q    <= res_occ_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_stall = out_valid_q && !rsp_ready;
	assign rsp_valid     = out_valid_q;
	assign status        = out_status_q;
	assign task_out      = out_task_q;
	assign occupancy     = out_occ_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_now <= ptr_t'(DEPTH))
		else $error("deque occupancy above depth");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> out_valid_q)
		else $error("loaded result not presented");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && operation == OP_PUSH && !full) |=>
		(occ_now == $past(occ_now) + ptr_t'(1)))
		else $error("accepted push did not advance occupancy");

endmodule

// ===== sv/work_stealing_deque.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// work_stealing_deque
// Serialized work-stealing deque of 256 task words of 64 bits.
// ----------------------------------------------------------------------------
// Each request is push (bottom), pop (bottom, LIFO) or steal (top, FIFO) and
// yields one response with status, the task taken and the occupancy after the
// request. At the accepting edge the pointers update and the ring entry is read
// into a register. When the output register does not stall, the result moves into
// it and the response becomes valid; only then is a new request taken. A finished
// response waits in the output register while the next request is accepted.
// The result of that next request then holds in the datapath, and further
// requests stall, until the waiting response is taken. A push on a full deque
// returns full and changes nothing; pop or steal on an empty deque returns empty
// with a zero task word. The ring needs no clearing after reset.
module work_stealing_deque import wsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	wsd_req_if.sink    req,
	wsd_rsp_if.source  rsp
);

	wsd_cmd_t cmd;
	wsd_sts_t sts;

	wsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	wsd_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.operation (req.operation),
		.task_in   (req.task_in),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.status    (rsp.status),
		.task_out  (rsp.task_out),
		.occupancy (rsp.occupancy)
	);

endmodule

// ===== verif/deque_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_checker
// Predicts every response of the work-stealing deque and checks it.
// ----------------------------------------------------------------------------
// Watches both channels. Each accepted request runs through a private copy of
// the ring and of the top and bottom pointers. The predicted status, task word
// and occupancy are queued in request order. Each accepted response is
// compared field by field with the oldest queued prediction. The failure count
// and the number of responses still owed go to the testbench top.
module deque_checker import wsd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	wsd_req_if   req,
	wsd_rsp_if   rsp,
	output int   errors,
	output int   pending
);

	typedef struct packed {
		status_t    status;
		task_t      word;
		logic [8:0] occupancy;
	} deque_result_t;

	task_t         shadow_ring [DEPTH];
	ptr_t          top_ptr;
	ptr_t          bottom_ptr;
	deque_result_t expected_results [$];

	function automatic deque_result_t apply_operation(logic [1:0] op, task_t word);
		deque_result_t res;
		ptr_t          held;
		res.status = ST_OK;
		res.word   = '0;
		held       = bottom_ptr - top_ptr;
		case (op)
			OP_PUSH: begin
				if (held == ptr_t'(DEPTH)) begin
					res.status = ST_FULL;
				end else begin
					shadow_ring[bottom_ptr[IDX_W-1:0]] = word;
					bottom_ptr = bottom_ptr + ptr_t'(1);
				end
			end
			OP_POP: begin
				if (held == '0) begin
					res.status = ST_EMPTY;
				end else begin
					bottom_ptr = bottom_ptr - ptr_t'(1);
					res.word = shadow_ring[bottom_ptr[IDX_W-1:0]];
				end
			end
			OP_STEAL: begin
				if (held == '0) begin
					res.status = ST_EMPTY;
				end else begin
					res.word = shadow_ring[top_ptr[IDX_W-1:0]];
					top_ptr = top_ptr + ptr_t'(1);
				end
			end
			default: begin
			end
		endcase
		res.occupancy = bottom_ptr - top_ptr;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		deque_result_t want;
		if (!arst_n) begin
			top_ptr    = '0;
			bottom_ptr = '0;
			expected_results.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: response with none expected: status %0d task %h occupancy %0d",
						$time, rsp.status, rsp.task_out, rsp.occupancy);
				end else begin
					want = expected_results.pop_front();
					if (rsp.status !== want.status) begin
						errors++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, rsp.status);
					end
					if (rsp.task_out !== 64'(want.word)) begin
						errors++;
						$display("%0t: task_out expected %h actual %h",
							$time, want.word, rsp.task_out);
					end
					if (rsp.occupancy !== want.occupancy) begin
						errors++;
						$display("%0t: occupancy expected %0d actual %0d",
							$time, want.occupancy, rsp.occupancy);
					end
				end
			end
			if (req.valid && req.ready) begin
				expected_results.push_back(apply_operation(req.operation, task_t'(req.task_in)));
			end
			pending = expected_results.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the work-stealing deque.
// ----------------------------------------------------------------------------
// Runs a short directed pass over empty, extreme and unused-code requests,
// fills the deque past full under a long response stall, drains it from both
// ends, then issues random operation mixes that swing the occupancy up and
// down. Both sides idle at random; some phases run without gaps.
module testbench;
	import wsd_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int         LIMIT     = 500000;
	localparam int         LONG_HOLD = 300;

	logic clk;
	logic arst_n;
	logic calm;
	logic hold_request;
	int   errors;
	int   pending;
	int   cycle_count = 0;

	wsd_req_if req ();
	wsd_rsp_if rsp ();

	work_stealing_deque uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	deque_checker deque_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic int idle_span();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic task_t random_word();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return {$urandom, $urandom};
	endfunction

	function automatic logic [1:0] random_operation(int push_weight);
		int r;
		r = $urandom_range(0, 99);
		if (r < push_weight) return OP_PUSH;
		if (r < push_weight + (95 - push_weight) / 2) return OP_POP;
		if (r < 95) return OP_STEAL;
		return OP_UNUSED;
	endfunction

	task automatic send_request(input logic [1:0] op, input task_t word);
		int gap;
		gap = idle_span();
		repeat (gap) begin
			@(negedge clk);
			req.valid <= 1'b0;
		end
		@(negedge clk);
		req.valid     <= 1'b1;
		req.operation <= op;
		req.task_in   <= word;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	// response side: random stalls, plus one long hold on request
	initial begin
		int stall;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				stall = LONG_HOLD;
			end else begin
				stall = idle_span();
			end
			repeat (stall) begin
				@(negedge clk);
				rsp.ready <= 1'b0;
			end
			@(negedge clk);
			rsp.ready <= 1'b1;
		end
	end

	initial begin
		int push_weight;
		arst_n        = 1'b0;
		calm          = 1'b0;
		hold_request  = 1'b0;
		req.valid     = 1'b0;
		req.operation = OP_PUSH;
		req.task_in   = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty deque, unused code, extremes, both ends
		send_request(OP_POP, '1);
		send_request(OP_STEAL, '1);
		send_request(OP_UNUSED, '1);
		send_request(OP_PUSH, '1);
		send_request(OP_PUSH, '0);
		send_request(OP_PUSH, 64'hAAAA_AAAA_AAAA_AAAA);
		send_request(OP_PUSH, 64'h5555_5555_5555_5555);
		send_request(OP_PUSH, 64'h8000_0000_0000_0001);
		send_request(OP_UNUSED, 64'h0123_4567_89AB_CDEF);
		send_request(OP_POP, '0);
		send_request(OP_STEAL, '0);
		send_request(OP_POP, '1);
		send_request(OP_STEAL, '0);
		send_request(OP_PUSH, 64'hFEDC_BA98_7654_3210);
		send_request(OP_POP, '0);
		send_request(OP_POP, '0);
		send_request(OP_STEAL, '0);
		send_request(OP_UNUSED, '0);

		// fill past full while responses are held off
		calm         = 1'b1;
		hold_request = 1'b1;
		repeat (DEPTH + 4) send_request(OP_PUSH, random_word());
		send_request(OP_STEAL, '0);
		send_request(OP_PUSH, random_word());
		send_request(OP_PUSH, random_word());
		send_request(OP_UNUSED, random_word());
		calm = 1'b0;

		// drain from both ends
		repeat (DEPTH + 4) begin
			send_request($urandom_range(0, 1) ? OP_POP : OP_STEAL, random_word());
		end

		// random mixes, alternating growth and drain bias
		for (int seg = 0; seg < 7; seg++) begin
			calm = (seg % 3 == 2);
			push_weight = (seg % 2 == 0) ? 65 : 30;
			repeat (95) send_request(random_operation(push_weight), random_word());
		end

		@(negedge clk);
		req.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== work_stealing_deque.f =====
sv/wsd_pkg.sv
sv/wsd_req_if.sv
sv/wsd_rsp_if.sv
sv/wsd_ctrl.sv
sv/wsd_dpath.sv
sv/work_stealing_deque.sv
verif/deque_checker.sv
verif/testbench.sv
